@@ rtl/ascii_integer_text_parser_macros.svh @@
// Assertion macros for the ASCII integer text parser checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASCII_INTEGER_TEXT_PARSER_MACROS_SVH
`define ASCII_INTEGER_TEXT_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AITP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define AITP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/aitp_pkg.sv @@
// Shared types, constants and helper functions for the ASCII integer parser.
// No dependencies; imported by every module of the block.
package aitp_pkg;

  localparam int VALUE_BITS  = 64;
  localparam int OFFSET_BITS = 16;
  localparam int CHAR_BITS   = 8;
  localparam int RADIX_BITS  = 6;
  localparam int DIGIT_BITS  = 7;

  localparam int S_TDATA_BITS = ((CHAR_BITS + RADIX_BITS + 7) / 8) * 8;
  localparam int M_TDATA_BITS = ((VALUE_BITS + OFFSET_BITS + 7) / 8) * 8;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX  = '1;
  localparam logic [DIGIT_BITS-1:0]  NOT_A_DIGIT = DIGIT_BITS'(99);
  localparam logic [RADIX_BITS-1:0]  RADIX_AUTO  = '0;
  localparam logic [RADIX_BITS-1:0]  RADIX_OCT   = RADIX_BITS'(8);
  localparam logic [RADIX_BITS-1:0]  RADIX_DEC   = RADIX_BITS'(10);
  localparam logic [RADIX_BITS-1:0]  RADIX_HEX   = RADIX_BITS'(16);

  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_LEAD     = 3'd1,
    PH_FIRST    = 3'd2,
    PH_ZERO     = 3'd3,
    PH_HEXSTART = 3'd4,
    PH_DIGITS   = 3'd5
  } phase_e;

  typedef struct packed {
    logic                  is_space;
    logic                  is_plus;
    logic                  is_minus;
    logic                  is_zero;
    logic                  is_x;
    logic [DIGIT_BITS-1:0] digit;
  } char_class_t;

  typedef struct packed {
    logic                   emit;
    logic [VALUE_BITS-1:0]  value;
    logic [OFFSET_BITS-1:0] end_offset;
    logic                   no_digits;
  } parse_result_t;

  function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
    logic [DIGIT_BITS-1:0] d;
    d = NOT_A_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = DIGIT_BITS'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = DIGIT_BITS'(c - CH_LA) + DIGIT_BITS'(10);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = DIGIT_BITS'(c - CH_UA) + DIGIT_BITS'(10);
    end
    return d;
  endfunction

endpackage

@@ rtl/ascii_integer_text_parser.sv @@
// ASCII integer parser with optional sign: input register, character step, result register.
// The result register loads from the character step when the held input character advances and a result is emitted.
// Throughput: one character per cycle; the input stage stalls while a character is
// held and an earlier result waits in the output register without being taken.
// Reset: asynchronous, active low; parser idle, both stages empty.
// Depends on aitp_pkg, aitp_char_class and aitp_core.
module ascii_integer_text_parser (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] char_code, [13:8] radix, [15:14] zero
  input  logic [aitp_pkg::S_TDATA_BITS-1:0] s_axis_tdata,
  // [0] start_req
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [63:0] value, [79:64] end_offset
  output logic [aitp_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
  // [0] no_digits
  output logic                              m_axis_tuser
);
  import aitp_pkg::*;

  logic                  in_valid_q;
  logic                  in_start_q;
  logic [CHAR_BITS-1:0]  in_char_q;
  logic [RADIX_BITS-1:0] in_radix_q;
  logic                  out_valid_q;
  logic [M_TDATA_BITS-1:0] out_data_q;
  logic                  out_none_q;

  logic          advance;
  char_class_t   cls;
  parse_result_t res;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_start_q <= s_axis_tuser;
      in_char_q  <= s_axis_tdata[CHAR_BITS-1:0];
      in_radix_q <= s_axis_tdata[CHAR_BITS+RADIX_BITS-1:CHAR_BITS];
    end
  end

  aitp_char_class u_class (
    .char_i (in_char_q),
    .cls_o  (cls)
  );

  aitp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .start_i  (in_start_q),
    .radix_i  (in_radix_q),
    .cls_i    (cls),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.emit) begin
      out_data_q <= M_TDATA_BITS'({res.end_offset, res.value});
      out_none_q <= res.no_digits;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_none_q;

endmodule

@@ rtl/aitp_char_class.sv @@
// Character classifier: whitespace, sign, zero, x and digit value.
// Depends on aitp_pkg.
module aitp_char_class (
  input  logic [aitp_pkg::CHAR_BITS-1:0] char_i,
  output aitp_pkg::char_class_t          cls_o
);
  import aitp_pkg::*;

  always_comb begin
    cls_o.is_space = (char_i == CH_SPACE) || (char_i >= CH_TAB && char_i <= CH_CR);
    cls_o.is_plus  = (char_i == CH_PLUS);
    cls_o.is_minus = (char_i == CH_MINUS);
    cls_o.is_zero  = (char_i == CH_ZERO);
    cls_o.is_x     = (char_i == CH_LX) || (char_i == CH_UX);
    cls_o.digit    = digit_of(char_i);
  end

endmodule

@@ rtl/aitp_core.sv @@
// Conversion state and per-character step: phase, accumulator, sign, radix, index.
// Depends on aitp_pkg; fed by aitp_char_class.
module aitp_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fire_i,
  input  logic                            start_i,
  input  logic [aitp_pkg::RADIX_BITS-1:0] radix_i,
  input  aitp_pkg::char_class_t           cls_i,
  output aitp_pkg::parse_result_t         result_o
);
  import aitp_pkg::*;

  phase_e                 ph_q, ph_d, ph_e;
  logic [VALUE_BITS-1:0]  acc_q, acc_d, acc_e;
  logic                   minus_q, minus_d, minus_e;
  logic [RADIX_BITS-1:0]  rad_q, rad_d, rad_e;
  logic [OFFSET_BITS-1:0] idx_q, idx_d, idx_e;
  logic                   taken_q, taken_d, taken_e;

  logic                          do_take;
  logic [VALUE_BITS+RADIX_BITS-1:0] prod;
  logic [VALUE_BITS-1:0]         mag;
  logic [OFFSET_BITS-1:0]        xpos;

  assign prod = acc_e * rad_d;

  always_comb begin
    ph_e    = ph_q;
    acc_e   = acc_q;
    minus_e = minus_q;
    rad_e   = rad_q;
    idx_e   = idx_q;
    taken_e = taken_q;
    if (start_i) begin
      ph_e    = PH_LEAD;
      acc_e   = '0;
      minus_e = 1'b0;
      rad_e   = radix_i;
      idx_e   = '0;
      taken_e = 1'b0;
    end else if (ph_q != PH_IDLE && idx_q < OFFSET_MAX) begin
      idx_e = idx_q + OFFSET_BITS'(1);
    end

    ph_d    = ph_e;
    acc_d   = acc_e;
    minus_d = minus_e;
    rad_d   = rad_e;
    idx_d   = idx_e;
    taken_d = taken_e;
    do_take = 1'b0;
    mag     = '0;
    result_o.emit       = 1'b0;
    result_o.end_offset = '0;
    result_o.no_digits  = 1'b0;

    xpos = (idx_e >= OFFSET_MAX) ? OFFSET_MAX : idx_e - OFFSET_BITS'(1);

    unique case (ph_e)
      PH_LEAD, PH_FIRST: begin
        if (ph_e == PH_LEAD && cls_i.is_space) begin
          ph_d = PH_LEAD;
        end else if (ph_e == PH_LEAD && (cls_i.is_plus || cls_i.is_minus)) begin
          minus_d = cls_i.is_minus;
          ph_d    = PH_FIRST;
        end else if (cls_i.is_zero && (rad_e == RADIX_AUTO || rad_e == RADIX_HEX)) begin
          ph_d = PH_ZERO;
        end else begin
          if (rad_e == RADIX_AUTO) rad_d = RADIX_DEC;
          do_take = 1'b1;
        end
      end
      PH_ZERO: begin
        if (cls_i.is_x) begin
          rad_d = RADIX_HEX;
          ph_d  = PH_HEXSTART;
        end else begin
          if (rad_e == RADIX_AUTO) rad_d = RADIX_OCT;
          taken_d = 1'b1;
          ph_d    = PH_DIGITS;
          do_take = 1'b1;
        end
      end
      PH_HEXSTART: begin
        if (cls_i.digit >= DIGIT_BITS'(rad_e)) begin
          result_o.emit       = 1'b1;
          result_o.end_offset = xpos;
          ph_d                = PH_IDLE;
        end else begin
          do_take = 1'b1;
        end
      end
      PH_DIGITS: do_take = 1'b1;
      PH_IDLE:   ph_d = PH_IDLE;
      default:   ph_d = PH_IDLE;
    endcase

    if (do_take) begin
      if (cls_i.digit >= DIGIT_BITS'(rad_d)) begin
        result_o.emit = 1'b1;
        ph_d          = PH_IDLE;
        if (taken_d) begin
          mag                 = acc_e;
          result_o.end_offset = idx_e;
        end else begin
          result_o.no_digits = 1'b1;
        end
      end else begin
        acc_d   = prod[VALUE_BITS-1:0] + VALUE_BITS'(cls_i.digit);
        taken_d = 1'b1;
        ph_d    = PH_DIGITS;
      end
    end

    result_o.value = minus_d ? (~mag + VALUE_BITS'(1)) : mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_IDLE;
      acc_q   <= '0;
      minus_q <= 1'b0;
      rad_q   <= '0;
      idx_q   <= '0;
      taken_q <= 1'b0;
    end else if (fire_i) begin
      ph_q    <= ph_d;
      acc_q   <= acc_d;
      minus_q <= minus_d;
      rad_q   <= rad_d;
      idx_q   <= idx_d;
      taken_q <= taken_d;
    end
  end

endmodule

@@ rtl/aitp_checker.sv @@
// Port-level checker for ascii_integer_text_parser, bound to the top level.
// Depends on aitp_pkg and ascii_integer_text_parser_macros.svh.
`include "ascii_integer_text_parser_macros.svh"

module aitp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [aitp_pkg::S_TDATA_BITS-1:0] s_axis_tdata,
  input logic                              s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [aitp_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
  input logic                              m_axis_tuser
);
  import aitp_pkg::*;

  logic s_xfer;
  logic nul_start;

  assign s_xfer    = s_axis_tvalid && s_axis_tready;
  assign nul_start = s_xfer && s_axis_tuser && (s_axis_tdata[CHAR_BITS-1:0] == '0);

  `AITP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  `AITP_ASSERT_NOW(a_no_digit_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "no-digit result carries nonzero value or offset")
  `AITP_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without a blocked result")
  `AITP_ASSERT_NEXT(a_nul_result, clk_i, rst_ni, (nul_start && m_axis_tready) ##1 m_axis_tready, m_axis_tvalid && m_axis_tuser && (m_axis_tdata == '0), "empty text did not give a no-digit result")

endmodule

bind ascii_integer_text_parser aitp_checker u_aitp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
